// ===== rtl/core/alr_pkg.sv =====
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants of the associated Legendre block
// Beat structs, sequencer states, multiply phases and the double factorial
// table used for the seed value.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int unsigned FRAC_BITS = 10;
  localparam int unsigned SEED_SH   = 60 - FRAC_BITS;
  localparam logic [0:0]  REG_MAX_DEGREE = 1'b0;
  localparam logic [3:0]  MAX_DEGREE_RESET = 4'd12;

  typedef struct packed {
    logic signed [31:0] arg_x;
    logic        [3:0]  order_m;
  } in_t;

  typedef struct packed {
    logic        [3:0]  degree_l;
    logic signed [63:0] value;
    logic               saturated;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_U, ST_SQRT, ST_PSEL, ST_MUL, ST_MWAIT, ST_POST,
    ST_STEP, ST_COMB, ST_ABS, ST_RND, ST_DIV, ST_PACK, ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    PH_POW, PH_ODD, PH_SEED, PH_T1, PH_T2
  } phase_e;

  // (2m-1)!! for m = 0..15
  function automatic logic [63:0] dfact(input logic [3:0] m);
    logic [63:0] v;
    unique case (m)
      4'd0:    v = 64'd1;
      4'd1:    v = 64'd1;
      4'd2:    v = 64'd3;
      4'd3:    v = 64'd15;
      4'd4:    v = 64'd105;
      4'd5:    v = 64'd945;
      4'd6:    v = 64'd10395;
      4'd7:    v = 64'd135135;
      4'd8:    v = 64'd2027025;
      4'd9:    v = 64'd34459425;
      4'd10:   v = 64'd654729075;
      4'd11:   v = 64'd13749310575;
      4'd12:   v = 64'd316234143225;
      4'd13:   v = 64'd7905853580625;
      4'd14:   v = 64'd213458046676875;
      default: v = 64'd6190283353629375;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/associated_legendre_recurrence_top.sv =====
// ----------------------------------------------------------------------------
// associated_legendre_recurrence_top: P_l^m(x) by upward recurrence
// The first beat follows a restoring square root and a chain of 64x64 products
// for the seed, each built from partial products on one 32x32 multiplier.
// Each further degree takes two products and a divider at 4 quotient bits
// per cycle. One item at a time; input stalls until the last beat of the run
// is loaded into the output register.
// Reset sets max_degree to 12.
// ----------------------------------------------------------------------------
module associated_legendre_recurrence_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  alr_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output alr_pkg::out_t       out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  alr_pkg::state_e state_q, state_d;
  alr_pkg::phase_e phase_q;

  logic [3:0]   max_degree_q;
  logic         out_valid_q;
  alr_pkg::out_t out_q;

  logic [30:0]  ax_q;
  logic         xneg_q;
  logic [3:0]   m_q, lim_q, l_q;
  logic         zero_q;
  logic [61:0]  sq_q;
  logic [63:0]  u_q, v_q, res_q, bit_q, q_q;
  logic [3:0]   pow_cnt_q;
  logic         odd_done_q;
  logic [63:0]  ma_q, mb_q, prod_q;
  logic [1:0]   idx_q, psh_q;
  logic         pv_q;
  logic [127:0] acc_q, t1_q, num_q, dv_q;
  logic         neg_q;
  logic [3:0]   rem_q;
  logic [4:0]   dcnt_q;
  logic [63:0]  p1_q, p2_q, rv_q;
  logic         rsat_q;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == alr_pkg::REG_MAX_DEGREE) ? {28'd0, max_degree_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_degree_q <= alr_pkg::MAX_DEGREE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == alr_pkg::REG_MAX_DEGREE) begin
      max_degree_q <= pwdata[3:0];
    end
  end

  assign in_stall_o  = (state_q != alr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // input argument magnitude, clamped to 1.0
  logic [31:0] xb, axu;
  logic        xneg;
  logic [30:0] ax_c;
  assign xb   = in_data_i.arg_x;
  assign xneg = xb[31];
  assign axu  = xneg ? (~xb + 32'd1) : xb;
  assign ax_c = (axu > 32'h4000_0000) ? 31'h4000_0000 : axu[30:0];

  logic last_c, emit_ok;
  assign last_c  = zero_q || (l_q == lim_q);
  assign emit_ok = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      alr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.order_m > max_degree_q) ? alr_pkg::ST_EMIT : alr_pkg::ST_SQ;
        end
      end
      alr_pkg::ST_SQ:    state_d = alr_pkg::ST_U;
      alr_pkg::ST_U:     state_d = alr_pkg::ST_SQRT;
      alr_pkg::ST_SQRT:  if (bit_q[0]) state_d = alr_pkg::ST_PSEL;
      alr_pkg::ST_PSEL:  state_d = alr_pkg::ST_MUL;
      alr_pkg::ST_MUL:   if (idx_q == 2'd3) state_d = alr_pkg::ST_MWAIT;
      alr_pkg::ST_MWAIT: state_d = alr_pkg::ST_POST;
      alr_pkg::ST_POST: begin
        unique case (phase_q)
          alr_pkg::PH_POW, alr_pkg::PH_ODD: state_d = alr_pkg::ST_PSEL;
          alr_pkg::PH_SEED:                 state_d = alr_pkg::ST_PACK;
          alr_pkg::PH_T1:                   state_d = alr_pkg::ST_MUL;
          default:                          state_d = alr_pkg::ST_COMB;
        endcase
      end
      alr_pkg::ST_STEP:  state_d = alr_pkg::ST_MUL;
      alr_pkg::ST_COMB:  state_d = alr_pkg::ST_ABS;
      alr_pkg::ST_ABS:   state_d = alr_pkg::ST_RND;
      alr_pkg::ST_RND:   state_d = alr_pkg::ST_DIV;
      alr_pkg::ST_DIV:   if (dcnt_q == 5'd31) state_d = alr_pkg::ST_PACK;
      alr_pkg::ST_PACK:  state_d = alr_pkg::ST_EMIT;
      alr_pkg::ST_EMIT: begin
        if (emit_ok) state_d = last_c ? alr_pkg::ST_IDLE : alr_pkg::ST_STEP;
      end
      default:           state_d = alr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == alr_pkg::ST_EMIT && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shared arithmetic
  logic [31:0]  mpa, mpb;
  logic [63:0]  mul_p;
  logic [127:0] acc_add;
  logic [63:0]  sq_sum;
  logic [63:0]  mag_p1, mag_p2;
  logic         s1, s2;
  logic [127:0] seed_rnd;
  logic [127:0] pow_rnd, odd_rnd;
  logic [4:0]   coef1, coef2;
  logic [3:0]   dsor;
  logic [127:0] div_dv;
  logic [3:0]   div_rem;
  logic [4:0]   r5;
  logic [63:0]  pack_v;
  logic         pack_s;

  assign mpa     = idx_q[0] ? ma_q[63:32] : ma_q[31:0];
  assign mpb     = idx_q[1] ? mb_q[63:32] : mb_q[31:0];
  assign mul_p   = {32'd0, mpa} * {32'd0, mpb};
  assign acc_add = acc_q + ({64'd0, prod_q} << {psh_q, 5'd0});
  assign sq_sum  = res_q + bit_q;
  assign mag_p1  = p1_q[63] ? (~p1_q + 64'd1) : p1_q;
  assign mag_p2  = p2_q[63] ? (~p2_q + 64'd1) : p2_q;
  assign s1      = p1_q[63] ^ xneg_q;
  assign s2      = p2_q[63];
  assign pow_rnd  = (acc_q + (128'd1 << 59)) >> 60;
  assign odd_rnd  = (acc_q + (128'd1 << 29)) >> 30;
  assign seed_rnd = (acc_q + (128'd1 << (alr_pkg::SEED_SH - 1))) >> alr_pkg::SEED_SH;
  assign coef1   = {l_q, 1'b0} - 5'd1;
  assign coef2   = 5'(l_q) + 5'(m_q) - 5'd1;
  assign dsor    = l_q - m_q;

  // four restoring quotient bits per cycle
  always_comb begin
    div_dv  = dv_q;
    div_rem = rem_q;
    r5      = 5'd0;
    for (int j = 0; j < 4; j++) begin
      r5     = {div_rem, div_dv[127]};
      div_dv = {div_dv[126:0], 1'b0};
      if (r5 >= {1'b0, dsor}) begin
        r5        = r5 - {1'b0, dsor};
        div_dv[0] = 1'b1;
      end
      div_rem = r5[3:0];
    end
  end

  // clip magnitude and sign to 64-bit two's complement
  always_comb begin
    pack_s = 1'b0;
    pack_v = dv_q[63:0];
    if (!neg_q) begin
      if (dv_q[127:63] != '0) begin
        pack_s = 1'b1;
        pack_v = 64'h7FFF_FFFF_FFFF_FFFF;
      end
    end else if (dv_q[127:64] != '0 || dv_q[63:0] > 64'h8000_0000_0000_0000) begin
      pack_s = 1'b1;
      pack_v = 64'h8000_0000_0000_0000;
    end else begin
      pack_v = ~dv_q[63:0] + 64'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    pv_q <= (state_q == alr_pkg::ST_MUL);
    if (pv_q) acc_q <= acc_add;
    unique case (state_q)
      alr_pkg::ST_IDLE: begin
        ax_q       <= ax_c;
        xneg_q     <= xneg;
        m_q        <= in_data_i.order_m;
        l_q        <= in_data_i.order_m;
        lim_q      <= max_degree_q;
        zero_q     <= (in_data_i.order_m > max_degree_q);
        rv_q       <= 64'd0;
        rsat_q     <= 1'b0;
        p1_q       <= 64'd0;
        p2_q       <= 64'd0;
        pow_cnt_q  <= 4'd0;
        odd_done_q <= 1'b0;
        q_q        <= 64'd1 << 60;
        // square x on the shared multiplier
        ma_q       <= {33'd0, ax_c};
        mb_q       <= {33'd0, ax_c};
        idx_q      <= 2'd0;
      end
      alr_pkg::ST_SQ: sq_q <= mul_p[61:0];
      alr_pkg::ST_U: begin
        u_q   <= (64'd1 << 60) - {2'd0, sq_q};
        v_q   <= (64'd1 << 60) - {2'd0, sq_q};
        res_q <= 64'd0;
        bit_q <= 64'd1 << 62;
      end
      alr_pkg::ST_SQRT: begin
        if (v_q >= sq_sum) begin
          v_q   <= v_q - sq_sum;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      alr_pkg::ST_PSEL: begin
        acc_q <= '0;
        idx_q <= 2'd0;
        if (pow_cnt_q < {1'b0, m_q[3:1]}) begin
          ma_q    <= q_q;
          mb_q    <= u_q;
          phase_q <= alr_pkg::PH_POW;
        end else if (m_q[0] && !odd_done_q) begin
          ma_q    <= q_q;
          mb_q    <= res_q;
          phase_q <= alr_pkg::PH_ODD;
        end else begin
          ma_q    <= alr_pkg::dfact(m_q);
          mb_q    <= q_q;
          phase_q <= alr_pkg::PH_SEED;
        end
      end
      alr_pkg::ST_MUL: begin
        prod_q <= mul_p;
        psh_q  <= 2'(idx_q[0]) + 2'(idx_q[1]);
        idx_q  <= idx_q + 2'd1;
      end
      alr_pkg::ST_POST: begin
        unique case (phase_q)
          alr_pkg::PH_POW: begin
            q_q       <= pow_rnd[63:0];
            pow_cnt_q <= pow_cnt_q + 4'd1;
          end
          alr_pkg::PH_ODD: begin
            q_q        <= odd_rnd[63:0];
            odd_done_q <= 1'b1;
          end
          alr_pkg::PH_SEED: begin
            dv_q  <= seed_rnd;
            neg_q <= m_q[0];
          end
          alr_pkg::PH_T1: begin
            t1_q    <= acc_q;
            acc_q   <= '0;
            idx_q   <= 2'd0;
            ma_q    <= {29'd0, coef2, 30'd0};
            mb_q    <= mag_p2;
            phase_q <= alr_pkg::PH_T2;
          end
          default: ;
        endcase
      end
      alr_pkg::ST_STEP: begin
        acc_q   <= '0;
        idx_q   <= 2'd0;
        ma_q    <= {59'd0, coef1} * {33'd0, ax_q};
        mb_q    <= mag_p1;
        phase_q <= alr_pkg::PH_T1;
      end
      alr_pkg::ST_COMB: num_q <= (s1 ? (~t1_q + 128'd1) : t1_q) +
                                 (s2 ? acc_q : (~acc_q + 128'd1));
      alr_pkg::ST_ABS: begin
        neg_q <= num_q[127];
        num_q <= num_q[127] ? (~num_q + 128'd1) : num_q;
      end
      alr_pkg::ST_RND: begin
        dv_q   <= (num_q + (128'(dsor) << 29)) >> 30;
        rem_q  <= 4'd0;
        dcnt_q <= 5'd0;
      end
      alr_pkg::ST_DIV: begin
        dv_q   <= div_dv;
        rem_q  <= div_rem;
        dcnt_q <= dcnt_q + 5'd1;
      end
      alr_pkg::ST_PACK: begin
        rv_q   <= pack_v;
        rsat_q <= pack_s;
      end
      alr_pkg::ST_EMIT: begin
        if (emit_ok) begin
          out_q.degree_l  <= l_q;
          out_q.value     <= rv_q;
          out_q.saturated <= rsat_q;
          out_q.last      <= last_c;
          // advance the recurrence pair
          p2_q <= p1_q;
          p1_q <= rv_q;
          if (!last_c) l_q <= l_q + 4'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== test/tb_associated_legendre_recurrence_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_associated_legendre_recurrence_top: self-checking bench for P_l^m(x)
// Drives (x, m) beats in random bursts, stalls the result side on its own
// pattern and checks every result beat against a fixed-point predictor of
// the seed and upward recurrence, across several max_degree settings.
// ----------------------------------------------------------------------------
module tb_associated_legendre_recurrence_top;

  localparam int unsigned LIMIT_CYCLES = 3_000_000;
  localparam logic [2:0]  ADDR_MAX_DEGREE = {alr_pkg::REG_MAX_DEGREE, 2'b00};
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  class legendre_scoreboard;
    alr_pkg::out_t pending_q[$];
    logic [3:0]    degree_limit;
    int unsigned   errors;
    int unsigned   beats_checked;

    function void set_limit(logic [3:0] v);
      degree_limit = v;
    endfunction

    function void queue_beat(alr_pkg::out_t o);
      pending_q = {pending_q, o};
    endfunction

    // restoring square root, one result bit per pass
    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] trial;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = (res | (64'd1 << b));
        if (trial * trial <= v) res = trial;
      end
      return res;
    endfunction

    function logic [63:0] clip(logic [127:0] mag, bit neg, output bit sat);
      sat = 0;
      if (!neg) begin
        if (mag >= 128'h8000_0000_0000_0000) begin
          sat = 1;
          return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return mag[63:0];
      end
      if (mag > 128'h8000_0000_0000_0000) begin
        sat = 1;
        return 64'h8000_0000_0000_0000;
      end
      return -mag[63:0];
    endfunction

    function logic [63:0] magnitude(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    // Predict every result of one (x, m) beat.
    function void note_input(alr_pkg::in_t d);
      logic [31:0]   xb;
      logic [63:0]   ax, u, r, q, dfac, p1, p2, pv;
      logic [127:0]  t, t1, t2, num;
      logic [3:0]    lim, m;
      bit            xneg, sat, neg;
      alr_pkg::out_t o;
      xb = d.arg_x;
      xneg = xb[31];
      ax = xneg ? {32'd0, -xb} : {32'd0, xb};
      if (xb == 32'h8000_0000) ax = 64'h8000_0000;
      if (ax > ONE_Q30) ax = ONE_Q30;
      m = d.order_m;
      lim = degree_limit;
      if (m > lim) begin
        o = '{degree_l: m, value: 0, saturated: 0, last: 1};
        queue_beat(o);
        return;
      end
      u = (64'd1 << 60) - ax * ax;
      r = int_sqrt(u);
      q = 64'd1 << 60;
      for (int i = 0; i < m / 2; i++) begin
        t = ({64'd0, q} * {64'd0, u} + (128'd1 << 59)) >> 60;
        q = t[63:0];
      end
      if (m[0]) begin
        t = ({64'd0, q} * {64'd0, r} + (128'd1 << 29)) >> 30;
        q = t[63:0];
      end
      dfac = 1;
      for (int k = 3; k < 2 * int'(m); k += 2) dfac = dfac * k;
      t = ({64'd0, dfac} * {64'd0, q} + (128'd1 << (alr_pkg::SEED_SH - 1)))
          >> alr_pkg::SEED_SH;
      p1 = clip(t, m[0], sat);
      p2 = 0;
      o = '{degree_l: m, value: p1, saturated: sat, last: (m == lim)};
      queue_beat(o);
      for (int l = m + 1; l <= lim; l++) begin
        logic [63:0] dv;
        dv = l - m;
        t1 = {64'd0, (2 * l - 1) * ax} * {64'd0, magnitude(p1)};
        t2 = {64'd0, 64'(l + m - 1) << 30} * {64'd0, magnitude(p2)};
        if (p1[63] != xneg) t1 = -t1;
        if (!p2[63]) t2 = -t2;
        num = t1 + t2;
        neg = num[127];
        if (neg) num = -num;
        num = ((num + (128'(dv) << 29)) >> 30) / dv;
        pv = clip(num, neg, sat);
        o = '{degree_l: 4'(l), value: pv, saturated: sat, last: (l == lim)};
        queue_beat(o);
        p2 = p1;
        p1 = pv;
      end
    endfunction

    function void check_result(alr_pkg::out_t got);
      alr_pkg::out_t want;
      beats_checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.degree_l !== want.degree_l) begin
        $display("%0t: degree_l expected %0d got %0d", $time, want.degree_l, got.degree_l);
        errors++;
      end
      if (got.value !== want.value) begin
        $display("%0t: value (l=%0d) expected %0d got %0d", $time, want.degree_l,
                 want.value, got.value);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b got %0b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  alr_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  alr_pkg::out_t out_data_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  legendre_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          hold_off_req = 0;
  bit          hold_off_done = 0;
  int unsigned hold_off_cnt = 0;

  associated_legendre_recurrence_top dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_associated_legendre_recurrence_top: FAIL");
      $finish;
    end
  end

  // Receiver: own stall pattern plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_off_req && !hold_off_done) begin
      out_stall_i <= 1'b1;
      hold_off_cnt <= hold_off_cnt + 1;
      if (hold_off_cnt == 600) hold_off_done <= 1'b1;
    end else if ((cycle_count / 2000) % 3 == 0) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 9) < 4);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  task automatic write_max_degree(logic [3:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_MAX_DEGREE;
    pwdata <= {28'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_limit(v);
  endtask

  task automatic send_beat(logic [31:0] x, logic [3:0] m);
    alr_pkg::in_t d;
    d.arg_x = x;
    d.order_m = m;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    in_data_i <= d;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(d);
    items_sent++;
    burst_left--;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (sb.pending_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_x();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? ONE_Q30 : -ONE_Q30;
      default: return $urandom_range(32'h8000_0000, 0) - ONE_Q30;
    endcase
  endfunction

  initial begin
    logic [3:0] settings[8];
    settings = '{4'd15, 4'd0, 4'd7, 4'd1, 4'd12, 4'd3, 4'd15, 4'd9};
    sb.set_limit(alr_pkg::MAX_DEGREE_RESET);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset degree limit of 12
    send_beat(32'd0, 4'd0);
    send_beat(ONE_Q30, 4'd0);
    send_beat(-ONE_Q30, 4'd1);
    send_beat(32'h8000_0000, 4'd2);
    send_beat(32'h7FFF_FFFF, 4'd3);
    send_beat(32'h2000_0000, 4'd12);
    send_beat(32'hE000_0001, 4'd13);
    send_beat(32'd1, 4'd15);
    send_beat(32'h3FFF_FFFF, 4'd5);
    send_beat(32'hC000_0001, 4'd11);
    send_beat(32'h1234_5678, 4'd8);
    drain();
    write_max_degree(4'd15);
    send_beat(32'h0000_4000, 4'd15);
    send_beat(32'hFFFF_C000, 4'd14);
    send_beat(32'h3000_0000, 4'd0);
    send_beat(32'h5555_5555, 4'd9);
    send_beat(32'hAAAA_AAAA, 4'd6);
    drain();

    foreach (settings[p]) begin
      logic [3:0] lim;
      lim = (p >= 5) ? 4'($urandom_range(0, 15)) : settings[p];
      write_max_degree(lim);
      if (p == 2) hold_off_req = 1;
      for (int i = 0; i < 37; i++) begin
        logic [3:0] m;
        m = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(0, lim));
        send_beat(rand_x(), m);
      end
      drain();
    end

    $display("Covered %0d input beats and %0d result beats over 10 degree limits,",
             items_sent, sb.beats_checked);
    $display("including extreme and clamped x, all orders and the order-above-limit case.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_associated_legendre_recurrence_top: PASS");
    end else begin
      $display("tb_associated_legendre_recurrence_top: FAIL");
    end
    $finish;
  end

endmodule
